### hw/rtl/xvht_pkg.sv
// Shared types, constants and helpers for the XOR-verified hash table.
// Used by xvht_store, xvht_ctrl and xor_verified_hash_table.
package xvht_pkg;

  // Table geometry
  localparam int TABLE_LOG2 = 12;
  localparam int SLOT_COUNT = 1 << TABLE_LOG2;

  // Item field widths
  localparam int KEY_W   = 64;
  localparam int SCORE_W = 16;
  localparam int EVAL_W  = 16;
  localparam int MOVE_W  = 16;
  localparam int DEPTH_W = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 4;

  // Size register reset value
  localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd12;

  // Function codes
  localparam logic FUNC_PROBE = 1'b0;
  localparam logic FUNC_SAVE  = 1'b1;

  // Principal variation node kind
  localparam logic [KIND_W-1:0] KIND_PV = 2'd0;

  // Depth bonus given to a new save against the stored depth
  localparam logic [DEPTH_W:0] DEPTH_MARGIN = 9'd4;

  typedef logic [TABLE_LOG2-1:0] slot_t;

  // Data word, score in the low bits; bits above kind are always zero
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DEPTH_W-1:0] depth;
    logic [MOVE_W-1:0]  move;
    logic [EVAL_W-1:0]  eval;
    logic [SCORE_W-1:0] score;
  } data_t;

  localparam int DATA_W = $bits(data_t);

  typedef struct packed {
    logic [KEY_W-1:0] check;
    data_t            data;
  } entry_t;

  // Memory access request from the sequencer
  typedef struct packed {
    logic   rd_en;
    slot_t  rd_slot;
    logic   wr_en;
    slot_t  wr_slot;
    entry_t wr_entry;
  } mem_req_t;

  // Data word widened to the key width
  function automatic logic [KEY_W-1:0] widen(input data_t d);
    return {{(KEY_W-DATA_W){1'b0}}, d};
  endfunction

  // Slot index: key masked to index_bits, saturating at the table size
  function automatic slot_t slot_of(input logic [KEY_W-1:0] key,
                                    input logic [CFG_W-1:0] bits);
    slot_t s;
    for (int i = 0; i < TABLE_LOG2; i++) begin
      s[i] = key[i] & (32'(bits) > i);
    end
    return s;
  endfunction

endpackage

### hw/rtl/xvht_store.sv
// Slot memory: one check word and one data word per slot.
// One write port, one read port with registered read data. Uses xvht_pkg.
module xvht_store
  import xvht_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_entry
);

  entry_t mem [SLOT_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_slot] <= req.wr_entry;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_entry <= mem[req.rd_slot];
    end
  end

endmodule

### hw/rtl/xvht_ctrl.sv
// Sequencer: clearing pass, probe/save read-modify-write and result register.
// Drives the slot memory in xvht_store through mem_req_t. Uses xvht_pkg.
module xvht_ctrl
  import xvht_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic [CFG_W-1:0]          index_bits,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      func,
  input  logic [KEY_W-1:0]          key,
  input  logic signed [SCORE_W-1:0] score,
  input  logic signed [EVAL_W-1:0]  pos_eval,
  input  logic [MOVE_W-1:0]         best_move,
  input  logic [DEPTH_W-1:0]        search_depth,
  input  logic [KIND_W-1:0]         node_kind,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic                      written,
  output logic signed [SCORE_W-1:0] found_score,
  output logic signed [EVAL_W-1:0]  found_eval,
  output logic [MOVE_W-1:0]         found_move,
  output logic [DEPTH_W-1:0]        found_depth,
  output logic [KIND_W-1:0]         found_kind,
  output mem_req_t                  req,
  input  entry_t                    rd_entry
);

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EVAL = 1'b1;

  logic  phase;
  logic  clearing;
  slot_t clr_slot;

  // Item held while its slot is read
  logic             func_q;
  logic [KEY_W-1:0] key_q;
  data_t            fresh_q;
  slot_t            slot_q;

  logic  accept;
  logic  cfg_wr;
  logic  out_load;
  logic  verified;
  logic  replace;
  data_t stored;
  data_t fresh_next;

  // Handshakes; a config write wins over an item in the same cycle
  assign cfg_ready = (phase == PH_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = clearing || (phase != PH_IDLE) || cfg_valid;
  assign accept    = in_valid && !in_stall;
  assign out_load  = (phase == PH_EVAL) && (!out_valid || !out_stall);

  // Pack the incoming fields
  always_comb begin
    fresh_next.score = score;
    fresh_next.eval  = pos_eval;
    fresh_next.move  = best_move;
    fresh_next.depth = search_depth;
    fresh_next.kind  = node_kind;
  end

  // Verify the slot and decide on replacement
  assign stored   = rd_entry.data;
  assign verified = (rd_entry.check ^ widen(stored)) == key_q;
  assign replace  = (fresh_q.kind == KIND_PV) || !verified ||
                    (({1'b0, fresh_q.depth} + DEPTH_MARGIN) > {1'b0, stored.depth});

  // Memory requests: read at accept, write back or clear
  always_comb begin
    req.rd_en    = accept;
    req.rd_slot  = slot_of(key, index_bits);
    req.wr_en    = 1'b0;
    req.wr_slot  = slot_q;
    req.wr_entry = '0;
    if (clearing) begin
      req.wr_en   = 1'b1;
      req.wr_slot = clr_slot;
    end else if (out_load && (func_q == FUNC_SAVE) && replace) begin
      req.wr_en          = 1'b1;
      req.wr_entry.check = key_q ^ widen(fresh_q);
      req.wr_entry.data  = fresh_q;
    end
  end

  // Clearing pass, one slot a cycle
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      clearing <= 1'b1;
      clr_slot <= '0;
    end else if (clearing) begin
      clr_slot <= clr_slot + 1'b1;
      if (&clr_slot) begin
        clearing <= 1'b0;
      end
    end
  end

  // Phase sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= PH_EVAL;
    end else if (out_load) begin
      phase <= PH_IDLE;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func;
      key_q   <= key;
      fresh_q <= fresh_next;
      slot_q  <= slot_of(key, index_bits);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit         <= (func_q == FUNC_PROBE) && verified;
      written     <= (func_q == FUNC_SAVE) && replace;
      found_score <= '0;
      found_eval  <= '0;
      found_move  <= '0;
      found_depth <= '0;
      found_kind  <= '0;
      if ((func_q == FUNC_PROBE) && verified) begin
        found_score <= stored.score;
        found_eval  <= stored.eval;
        found_move  <= stored.move;
        found_depth <= stored.depth;
        found_kind  <= stored.kind;
      end
    end
  end

  // An accepted item is evaluated next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    accept |=> (phase == PH_EVAL))
    else $error("accepted item did not enter evaluation");

  // No item is in flight during a clearing pass
  a_no_eval_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EVAL) |-> !clearing)
    else $error("item evaluated during clearing pass");

  // A stalled evaluation keeps its slot and writes nothing
  a_eval_hold: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_EVAL) && !out_load) |-> !req.wr_en ##1 ((phase == PH_EVAL) && $stable(slot_q)))
    else $error("stalled evaluation lost its slot or wrote early");

  // Memory writes come only from clearing or a completing save
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    req.wr_en |-> (clearing || (out_load && (func_q == FUNC_SAVE))))
    else $error("unexpected slot memory write");

endmodule

### hw/rtl/xor_verified_hash_table.sv
// XOR-verified, depth-preferred direct-mapped hash table, top level.
// Holds the size register and joins xvht_ctrl to xvht_store. Uses xvht_pkg.
//
// For each item the slot is read from the synchronous memory, then the
// result is registered and a save writes the slot back. A new item is not
// taken until the last one's result has been loaded into the result
// register. Results are one per item and in order. After reset, and after
// every write of index_bits, a clearing pass zeroes all 4096 slots, one per
// cycle; during the pass no item is accepted (in_stall is high), while
// configuration writes are still taken and restart the pass.
module xor_verified_hash_table
  import xvht_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      func,
  input  logic [KEY_W-1:0]          key,
  input  logic signed [SCORE_W-1:0] score,
  input  logic signed [EVAL_W-1:0]  pos_eval,
  input  logic [MOVE_W-1:0]         best_move,
  input  logic [DEPTH_W-1:0]        search_depth,
  input  logic [KIND_W-1:0]         node_kind,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic                      written,
  output logic signed [SCORE_W-1:0] found_score,
  output logic signed [EVAL_W-1:0]  found_eval,
  output logic [MOVE_W-1:0]         found_move,
  output logic [DEPTH_W-1:0]        found_depth,
  output logic [KIND_W-1:0]         found_kind
);

  logic [CFG_W-1:0] index_bits;
  mem_req_t         req;
  entry_t           rd_entry;

  // Size register
  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= INDEX_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      index_bits <= cfg_data;
    end
  end

  xvht_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .index_bits   (index_bits),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .key          (key),
    .score        (score),
    .pos_eval     (pos_eval),
    .best_move    (best_move),
    .search_depth (search_depth),
    .node_kind    (node_kind),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .written      (written),
    .found_score  (found_score),
    .found_eval   (found_eval),
    .found_move   (found_move),
    .found_depth  (found_depth),
    .found_kind   (found_kind),
    .req          (req),
    .rd_entry     (rd_entry)
  );

  xvht_store u_store (
    .clk      (clk),
    .req      (req),
    .rd_entry (rd_entry)
  );

endmodule
